### hw/rtl/pct_pkg.sv
package pct_pkg;

	// Default configuration
	localparam int CAPACITY_DEF   = 1024;
	localparam int WORD_WIDTH_DEF = 32;

	// Port field widths
	localparam int OP_W     = 2;
	localparam int ID_W     = 10;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
	localparam logic [OP_W-1:0] OP_GET     = 2'd2;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

### hw/rtl/pct_ram.sv
module pct_ram
	import pct_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = WORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/packed_component_table_core.sv
// Channel   Handshake            Ports
// request   start & !busy        op, entity_id, component_data
// result    done (one cycle)     read_data, status, stored_count
//
// Each request: sparse and dense RAM reads at accept, an execute state that
// writes the RAMs if the table changes, and a finish state with the result.
// A new request is taken in the cycle after done.
// After reset the presence bits in the sparse RAM are swept to zero, one
// entry a cycle, with busy high.
// Results are shown for exactly one cycle; the receiver cannot stall them.
module packed_component_table_core
	import pct_pkg::*;
#(
	parameter int ENTITY_CAPACITY = CAPACITY_DEF,
	parameter int WORD_WIDTH      = WORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     op,
	input  logic [ID_W-1:0]     entity_id,
	input  logic [DATA_W-1:0]   component_data,
	output logic                busy,
	output logic                done,
	output logic [DATA_W-1:0]   read_data,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  stored_count
);

	localparam int IDX_W = $clog2(ENTITY_CAPACITY);
	localparam int CNT_W = $clog2(ENTITY_CAPACITY + 1);
	localparam int SP_W  = IDX_W + 1;
	localparam int DN_W  = IDX_W + WORD_WIDTH;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      clr_q;
	logic [CNT_W-1:0]      count_q;
	logic [OP_W-1:0]       op_q;
	logic [IDX_W-1:0]      id_q;
	logic [WORD_WIDTH-1:0] data_q;
	logic                  in_range_q;
	logic                  hit_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  accept;
	logic                  in_range;
	logic                  present;
	logic                  full;
	logic [IDX_W-1:0]      hole;
	logic [IDX_W-1:0]      moved;
	logic [IDX_W-1:0]      last_idx;
	logic [STATUS_W-1:0]   status_d;

	logic                  sp_we;
	logic [IDX_W-1:0]      sp_waddr;
	logic [SP_W-1:0]       sp_wdata;
	logic [SP_W-1:0]       sp_rdata;
	logic                  dn_we;
	logic [IDX_W-1:0]      dn_waddr;
	logic [DN_W-1:0]       dn_wdata;
	logic                  dn_re;
	logic [IDX_W-1:0]      dn_raddr;
	logic [DN_W-1:0]       dn_rdata;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign in_range = (32'(entity_id) < 32'(ENTITY_CAPACITY));

	// Sparse entry: {present, slot}; dense entry: {entity, word}
	assign present  = sp_rdata[IDX_W] && in_range_q;
	assign hole     = sp_rdata[IDX_W-1:0];
	assign moved    = dn_rdata[DN_W-1 -: IDX_W];
	assign full     = (count_q == CNT_W'(ENTITY_CAPACITY));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// Fetch last slot at accept; fetch the entity's own slot for a get hit
	assign dn_re    = accept || ((state_q == S_EXEC) && (op_q == OP_GET) && present);
	assign dn_raddr = (state_q == S_EXEC) ? hole : last_idx;

	always_comb begin
		sp_we    = 1'b0;
		sp_waddr = clr_q;
		sp_wdata = '0;
		dn_we    = 1'b0;
		dn_waddr = hole;
		dn_wdata = dn_rdata;
		status_d = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				sp_we = 1'b1;
			end
			S_IDLE: begin
			end
			S_EXEC: begin
				case (op_q) inside
					OP_INSERT: begin
						if (present) begin
							status_d = ST_PRESENT;
						end else if (!in_range_q || full) begin
							status_d = ST_FULL;
						end else begin
							sp_we    = 1'b1;
							sp_waddr = id_q;
							sp_wdata = {1'b1, IDX_W'(count_q)};
							dn_we    = 1'b1;
							dn_waddr = IDX_W'(count_q);
							dn_wdata = {id_q, data_q};
						end
					end
					OP_REMOVE, OP_DESTROY: begin
						if (present) begin
							// move last word into the hole, repoint the moved entity
							dn_we    = 1'b1;
							sp_we    = 1'b1;
							sp_waddr = moved;
							sp_wdata = {1'b1, hole};
						end else if (op_q == OP_REMOVE) begin
							status_d = ST_ABSENT;
						end
					end
					default: begin
						if (!present) begin
							status_d = ST_ABSENT;
						end
					end
				endcase
			end
			S_FIN: begin
				// drop the presence bit last so removing the tail entity ends cleared
				if (hit_q && ((op_q == OP_REMOVE) || (op_q == OP_DESTROY))) begin
					sp_we    = 1'b1;
					sp_waddr = id_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			count_q  <= '0;
			op_q     <= OP_INSERT;
			hit_q    <= 1'b0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ENTITY_CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= op;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					hit_q    <= present;
					status_q <= status_d;
					if (op_q == OP_INSERT) begin
						if (!present && in_range_q && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if ((op_q == OP_REMOVE) || (op_q == OP_DESTROY)) begin
						if (present) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q       <= IDX_W'(entity_id);
			data_q     <= WORD_WIDTH'(component_data);
			in_range_q <= in_range;
		end
	end

	assign done         = (state_q == S_FIN);
	assign status       = status_q;
	assign stored_count = COUNT_W'(count_q);
	assign read_data    = ((op_q == OP_GET) && hit_q) ? DATA_W'(dn_rdata[WORD_WIDTH-1:0]) : '0;

	pct_ram #(
		.DEPTH (ENTITY_CAPACITY),
		.WIDTH (SP_W)
	) u_sparse (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.re    (accept),
		.raddr (IDX_W'(entity_id)),
		.rdata (sp_rdata)
	);

	pct_ram #(
		.DEPTH (ENTITY_CAPACITY),
		.WIDTH (DN_W)
	) u_dense (
		.clk   (clk),
		.we    (dn_we),
		.waddr (dn_waddr),
		.wdata (dn_wdata),
		.re    (dn_re),
		.raddr (dn_raddr),
		.rdata (dn_rdata)
	);

endmodule

### bench/packed_component_table_core_tb.sv
module packed_component_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pct_pkg::*;

	localparam int CAPACITY   = CAPACITY_DEF;
	localparam int RANDOM_OPS = 680;
	localparam int CALM_TAIL  = 150;
	localparam int STALL_MAX  = 6000;
	localparam int DRAIN_WAIT = 8;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] data;
	} request_t;

	typedef struct {
		logic [DATA_W-1:0]   read_data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  stored_count;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OP_W-1:0]     op = OP_GET;
	logic [ID_W-1:0]     entity_id = '0;
	logic [DATA_W-1:0]   component_data = '0;
	logic                busy;
	logic                done;
	logic [DATA_W-1:0]   read_data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  stored_count;

	request_t request_q[$];
	outcome_t outcome_q[$];
	int       fail_count = 0;
	int       idle_left = 0;
	int       stall_cycles = 0;

	// Table as the stimulus plan leaves it, used to aim ids at live entities
	bit               plan_live[CAPACITY];
	int               plan_pos[CAPACITY];
	logic [ID_W-1:0]  plan_ids[$];

	// Predicted table contents
	bit                 mirror_live[CAPACITY];
	logic [ID_W-1:0]    mirror_slot[CAPACITY];
	logic [ID_W-1:0]    mirror_owner[CAPACITY];
	logic [DATA_W-1:0]  mirror_word[CAPACITY];
	logic [COUNT_W-1:0] mirror_count = '0;

	packed_component_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.op             (op),
		.entity_id      (entity_id),
		.component_data (component_data),
		.busy           (busy),
		.done           (done),
		.read_data      (read_data),
		.status         (status),
		.stored_count   (stored_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void plan(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
			logic [DATA_W-1:0] d);
		int pos;
		request_q.push_back('{op: o, id: id, data: d});
		if (o == OP_INSERT && !plan_live[id] && plan_ids.size() < CAPACITY) begin
			plan_live[id] = 1'b1;
			plan_pos[id] = plan_ids.size();
			plan_ids.push_back(id);
		end else if ((o == OP_REMOVE || o == OP_DESTROY) && plan_live[id]) begin
			pos = plan_pos[id];
			plan_ids[pos] = plan_ids[plan_ids.size() - 1];
			plan_pos[plan_ids[pos]] = pos;
			void'(plan_ids.pop_back());
			plan_live[id] = 1'b0;
		end
	endfunction

	function automatic logic [ID_W-1:0] pick_live();
		return plan_ids[$urandom_range(0, plan_ids.size() - 1)];
	endfunction

	function automatic logic [ID_W-1:0] pick_free();
		logic [ID_W-1:0] id;
		do
			id = ID_W'($urandom_range(0, CAPACITY - 1));
		while (plan_live[id]);
		return id;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic void predict(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
			logic [DATA_W-1:0] d);
		outcome_t r;
		logic [ID_W-1:0] hole;
		logic [ID_W-1:0] last;
		logic [ID_W-1:0] moved;
		r.read_data = '0;
		r.status = ST_OK;
		case (o)
			OP_INSERT: begin
				if (mirror_live[id]) begin
					r.status = ST_PRESENT;
				end else if (mirror_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					mirror_slot[id] = mirror_count[ID_W-1:0];
					mirror_owner[mirror_count[ID_W-1:0]] = id;
					mirror_word[mirror_count[ID_W-1:0]] = d;
					mirror_live[id] = 1'b1;
					mirror_count = mirror_count + 1'b1;
				end
			end
			OP_GET: begin
				if (mirror_live[id])
					r.read_data = mirror_word[mirror_slot[id]];
				else
					r.status = ST_ABSENT;
			end
			default: begin
				if (mirror_live[id]) begin
					// fill the hole with the last slot's word and owner
					hole = mirror_slot[id];
					last = ID_W'(mirror_count - 1'b1);
					moved = mirror_owner[last];
					mirror_word[hole] = mirror_word[last];
					mirror_slot[moved] = hole;
					mirror_owner[hole] = moved;
					mirror_live[id] = 1'b0;
					mirror_count = mirror_count - 1'b1;
				end else if (o == OP_REMOVE) begin
					r.status = ST_ABSENT;
				end
			end
		endcase
		r.stored_count = mirror_count;
		outcome_q.push_back(r);
	endfunction

	always @(posedge clk) begin
		request_t item;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else if (!start || !busy) begin
			if (start)
				predict(op, entity_id, component_data);
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (request_q.size() > CALM_TAIL && (request_q.size() % 200) < 120
					&& $urandom_range(0, 4) == 0) begin
				idle_left = $urandom_range(0, 3);
				start <= 1'b0;
			end else if (request_q.size() != 0) begin
				item = request_q.pop_front();
				start <= 1'b1;
				op <= item.op;
				entity_id <= item.id;
				component_data <= item.data;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result with no request outstanding: status %0d stored_count %0d",
					status, stored_count);
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (stored_count !== want.stored_count) begin
					$error("stored_count: expected %0d, got %0d",
						want.stored_count, stored_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int roll;
		logic [ID_W-1:0] id;

		// empty table: every miss path
		plan(OP_GET, 0, '1);
		plan(OP_REMOVE, 1023, '0);
		plan(OP_DESTROY, 5, '1);
		// extreme ids and words, then a duplicate insert
		plan(OP_INSERT, 0, '0);
		plan(OP_INSERT, 1023, '1);
		plan(OP_INSERT, 0, 32'h1234_5678);
		plan(OP_GET, 0, '0);
		plan(OP_GET, 1023, '0);
		plan(OP_INSERT, 512, 32'hA5A5_5A5A);
		// removing slot 0 moves entity 512 down into it
		plan(OP_REMOVE, 0, '0);
		plan(OP_GET, 512, '0);
		plan(OP_GET, 1023, '0);
		plan(OP_DESTROY, 1023, '0);
		plan(OP_DESTROY, 1023, '0);
		plan(OP_REMOVE, 1023, '0);
		plan(OP_GET, 1023, '0);
		plan(OP_INSERT, 341, 32'h5555_5555);
		plan(OP_INSERT, 682, 32'hAAAA_AAAA);
		// the last slot removes itself
		plan(OP_REMOVE, 682, '0);
		plan(OP_GET, 341, '0);
		plan(OP_DESTROY, 512, '0);
		plan(OP_GET, 341, '0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			roll = $urandom_range(0, 99);
			if (plan_ids.size() == 0 || roll < 35) begin
				plan(OP_INSERT, pick_free(), pick_word());
			end else if (roll < 55) begin
				plan(OP_GET, pick_live(), pick_word());
			end else if (roll < 70) begin
				plan(OP_REMOVE, pick_live(), pick_word());
			end else if (roll < 78) begin
				plan(OP_DESTROY, pick_live(), pick_word());
			end else begin
				// noise: any op, ids crowded into a small range half the time
				id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15))
					: ID_W'($urandom_range(0, 1023));
				plan(OP_W'($urandom_range(0, 3)), id, pick_word());
			end
		end

		// drain with swaps all the way down
		plan(OP_GET, 0, '0);
		plan(OP_GET, 1023, '0);
		while (plan_ids.size() != 0) begin
			roll = $urandom_range(0, 9);
			if (roll < 2)
				plan(OP_GET, pick_live(), pick_word());
			else
				plan(roll < 6 ? OP_REMOVE : OP_DESTROY, pick_live(), pick_word());
		end
		plan(OP_GET, ID_W'($urandom_range(0, 1023)), '0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || start || outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
